/* rtl/mqs_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and codes of the message queue with id search
package mqs_pkg;

  // queue geometry
  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int ID_W     = 29;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((ID_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_BODY_W  = ID_W + DATA_W + OCC_W;
  localparam int OUT_TDATA_W = ((OUT_BODY_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BODY_W;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // controller to slot store: one read address, three write ports
  typedef struct packed {
    slot_t             rd_addr;
    logic              msg_we;
    slot_t             msg_addr;
    logic [ID_W-1:0]   msg_id;
    logic [DATA_W-1:0] msg_data;
    logic              nxt_we;
    slot_t             nxt_addr;
    slot_t             nxt_val;
    logic              prv_we;
    slot_t             prv_addr;
    slot_t             prv_val;
  } st_req_t;

  // slot store to controller: registered read data
  typedef struct packed {
    logic [ID_W-1:0]   msg_id;
    logic [DATA_W-1:0] msg_data;
    slot_t             nxt;
    slot_t             prv;
  } st_rsp_t;

endpackage

/* rtl/mqs_store.sv */
`timescale 1ns / 1ps
// slot store: message and link memories with one registered read port
module mqs_store (
  input  logic             clk,
  input  mqs_pkg::st_req_t req,
  output mqs_pkg::st_rsp_t rsp
);

  logic [mqs_pkg::ID_W-1:0]   id_mem   [mqs_pkg::DEPTH];
  logic [mqs_pkg::DATA_W-1:0] data_mem [mqs_pkg::DEPTH];
  mqs_pkg::slot_t             next_mem [mqs_pkg::DEPTH];
  mqs_pkg::slot_t             prev_mem [mqs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.msg_we) begin
      id_mem[req.msg_addr]   <= req.msg_id;
      data_mem[req.msg_addr] <= req.msg_data;
    end
    if (req.nxt_we) begin
      next_mem[req.nxt_addr] <= req.nxt_val;
    end
    if (req.prv_we) begin
      prev_mem[req.prv_addr] <= req.prv_val;
    end
  end

  always_ff @(posedge clk) begin
    rsp.msg_id   <= id_mem[req.rd_addr];
    rsp.msg_data <= data_mem[req.rd_addr];
    rsp.nxt      <= next_mem[req.rd_addr];
    rsp.prv      <= prev_mem[req.rd_addr];
  end

endmodule

/* rtl/mqs_ctrl.sv */
`timescale 1ns / 1ps
// queue controller: slot allocation, list walk, unlink and result register
module mqs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mqs_pkg::OP_W-1:0]     in_op,
  input  logic [mqs_pkg::ID_W-1:0]     in_id,
  input  logic [mqs_pkg::DATA_W-1:0]   in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mqs_pkg::STATUS_W-1:0] out_status,
  output logic [mqs_pkg::ID_W-1:0]     out_id,
  output logic [mqs_pkg::DATA_W-1:0]   out_data,
  output logic [mqs_pkg::OCC_W-1:0]    out_occ,
  output mqs_pkg::st_req_t             st_req,
  input  mqs_pkg::st_rsp_t             st_rsp
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  mqs_pkg::status_t              out_status_r;
  logic [mqs_pkg::ID_W-1:0]      out_id_r;
  logic [mqs_pkg::DATA_W-1:0]    out_data_r;
  logic [mqs_pkg::OCC_W-1:0]     out_occ_r;
  logic [mqs_pkg::DEPTH-1:0]     used_r;
  mqs_pkg::slot_t                oldest_r;
  mqs_pkg::slot_t                newest_r;
  mqs_pkg::cnt_t                 count_r;
  mqs_pkg::cnt_t                 left_r;
  mqs_pkg::slot_t                cur_r;
  logic [mqs_pkg::ID_W-1:0]      key_r;
  logic                          pop_r;

  logic                          accept;
  logic                          full;
  logic                          hit;
  mqs_pkg::slot_t                free_slot;
  mqs_pkg::op_t                  op;

  // lowest clear bit of the used map
  function automatic mqs_pkg::slot_t lowest_free(input logic [mqs_pkg::DEPTH-1:0] used);
    mqs_pkg::slot_t idx;
    logic           found;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < mqs_pkg::DEPTH; i++) begin
      if (!found && !used[i]) begin
        idx   = mqs_pkg::SLOT_W'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

  assign op        = mqs_pkg::op_t'(in_op);
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r >= mqs_pkg::CNT_W'(mqs_pkg::DEPTH));
  assign free_slot = lowest_free(used_r);
  assign hit       = pop_r || (st_rsp.msg_id == key_r);

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_data   = out_data_r;
  assign out_occ    = out_occ_r;

  // store requests: read the list head while idle, follow the link while walking
  always_comb begin
    st_req          = '0;
    st_req.rd_addr  = (state_r == S_WALK) ? st_rsp.nxt : oldest_r;
    st_req.msg_addr = free_slot;
    st_req.msg_id   = in_id;
    st_req.msg_data = in_data;
    if (accept && (op == mqs_pkg::OP_PUSH) && !full) begin
      st_req.msg_we = 1'b1;
      if (count_r != '0) begin
        st_req.nxt_we   = 1'b1;
        st_req.nxt_addr = newest_r;
        st_req.nxt_val  = free_slot;
        st_req.prv_we   = 1'b1;
        st_req.prv_addr = free_slot;
        st_req.prv_val  = newest_r;
      end
    end
    if ((state_r == S_WALK) && hit) begin
      if (cur_r != oldest_r) begin
        st_req.nxt_we   = 1'b1;
        st_req.nxt_addr = st_rsp.prv;
        st_req.nxt_val  = st_rsp.nxt;
      end
      if (cur_r != newest_r) begin
        st_req.prv_we   = 1'b1;
        st_req.prv_addr = st_rsp.nxt;
        st_req.prv_val  = st_rsp.prv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      left_r      <= '0;
      pop_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_id_r   <= '0;
            out_data_r <= '0;
            out_occ_r  <= mqs_pkg::OCC_W'(count_r);
            unique case (op)
              mqs_pkg::OP_PUSH: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_status_r <= mqs_pkg::ST_FULL;
                end else begin
                  out_status_r      <= mqs_pkg::ST_OK;
                  out_occ_r         <= mqs_pkg::OCC_W'(count_r + 1'b1);
                  used_r[free_slot] <= 1'b1;
                  if (count_r == '0) begin
                    oldest_r <= free_slot;
                  end
                  newest_r <= free_slot;
                  count_r  <= count_r + 1'b1;
                end
              end
              mqs_pkg::OP_POP, mqs_pkg::OP_FIND: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= (op == mqs_pkg::OP_POP) ? mqs_pkg::ST_EMPTY
                                                          : mqs_pkg::ST_NOT_FOUND;
                end else begin
                  state_r <= S_WALK;
                  cur_r   <= oldest_r;
                  left_r  <= count_r;
                  key_r   <= in_id;
                  pop_r   <= (op == mqs_pkg::OP_POP);
                end
              end
              mqs_pkg::OP_NOP: begin
                out_valid_r  <= 1'b1;
                out_status_r <= mqs_pkg::ST_OK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (hit) begin
            state_r       <= S_IDLE;
            out_valid_r   <= 1'b1;
            out_status_r  <= mqs_pkg::ST_OK;
            out_id_r      <= st_rsp.msg_id;
            out_data_r    <= st_rsp.msg_data;
            out_occ_r     <= mqs_pkg::OCC_W'(count_r - 1'b1);
            used_r[cur_r] <= 1'b0;
            count_r       <= count_r - 1'b1;
            // list ends only move when something stays on the list
            if (count_r != mqs_pkg::CNT_W'(1)) begin
              if (cur_r == oldest_r) begin
                oldest_r <= st_rsp.nxt;
              end
              if (cur_r == newest_r) begin
                newest_r <= st_rsp.prv;
              end
            end
          end else if (left_r == mqs_pkg::CNT_W'(1)) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= mqs_pkg::ST_NOT_FOUND;
            out_id_r     <= '0;
            out_data_r   <= '0;
            out_occ_r    <= mqs_pkg::OCC_W'(count_r);
          end else begin
            left_r <= left_r - 1'b1;
            cur_r  <= st_rsp.nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mqs_pkg::CNT_W'(mqs_pkg::DEPTH))
    else $error("stored count above queue depth");

  a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("used map disagrees with stored count");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((left_r != '0) && (left_r <= count_r)))
    else $error("walk step count out of range");

  a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !out_valid_r)
    else $error("result pending during a walk");

  a_walk_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> used_r[cur_r])
    else $error("walk reached a free slot");

endmodule

/* rtl/message_queue_with_id_search.sv */
`timescale 1ns / 1ps
// top level of the message queue with id search
//
//  channel | direction | tdata (low bit up)                    | tuser
//  --------+-----------+---------------------------------------+-------------
//  in_     | slave     | msg_id[28:0], msg_data[63:0], pad      | op[1:0]
//  out_    | master    | out_id[28:0], out_data[63:0],          | status[1:0]
//          |           | occupancy[4:0], pad                    |
//
// a push is answered from the idle state; a pop reads the list head while idle, then unlinks it in the walk state;
// a find reads the list head, then walks one slot at a time, up to the occupancy,
// since the single read port of the slot store follows the links
// reset clears the control state and the used map; slot memories are not cleared
// a word is taken while idle and the result register is free or being drained;
// a stalled result holds in the output register
module message_queue_with_id_search (
  input  logic                            clk,
  input  logic                            rst_n,
  // input word
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mqs_pkg::IN_TDATA_W-1:0]  in_tdata,  // msg_id, msg_data
  input  logic [mqs_pkg::OP_W-1:0]        in_tuser,  // op
  // result word
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mqs_pkg::OUT_TDATA_W-1:0] out_tdata, // out_id, out_data, occupancy
  output logic [mqs_pkg::STATUS_W-1:0]    out_tuser  // status
);

  mqs_pkg::st_req_t              st_req;
  mqs_pkg::st_rsp_t              st_rsp;
  logic [mqs_pkg::ID_W-1:0]      res_id;
  logic [mqs_pkg::DATA_W-1:0]    res_data;
  logic [mqs_pkg::OCC_W-1:0]     res_occ;

  // controller: allocation, walk and result register
  mqs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_id      (in_tdata[mqs_pkg::ID_W-1:0]),
    .in_data    (in_tdata[mqs_pkg::ID_W+mqs_pkg::DATA_W-1:mqs_pkg::ID_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_id     (res_id),
    .out_data   (res_data),
    .out_occ    (res_occ),
    .st_req     (st_req),
    .st_rsp     (st_rsp)
  );

  // message and link memories
  mqs_store u_store (
    .clk (clk),
    .req (st_req),
    .rsp (st_rsp)
  );

  // pack the result word, id in the low bits
  assign out_tdata = {{mqs_pkg::OUT_PAD_W{1'b0}}, res_occ, res_data, res_id};

endmodule
